@@ design/assert_macros.svh @@
// Assertion macros used by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clock, reset, cond, expr)
`define ASSERT_NEXT(label, clock, reset, cond, expr)
`endif
`endif

@@ design/slvs_pkg.sv @@
// Types and constants of the scissor lift valve sequencer.
`timescale 1ns / 1ps
`default_nettype none
package slvs_pkg;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_UP_WAIT, SQ_UP_RUN, SQ_DN_1, SQ_DN_2, SQ_DN_DROP, SQ_LOCKED, SQ_REFILL
  } seq_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RISING, ST_DROPPING, ST_LOCKED, ST_REFILLING
  } status_t;

  typedef enum logic [3:0] {
    EV_NONE, EV_UP_START, EV_UP_LIMIT, EV_UP_RELEASE, EV_DOWN_START, EV_DOWN_RELEASE,
    EV_LOCK_START, EV_LOCK_STOP, EV_REFILL_START, EV_REFILL_STOP, EV_ROLE_SWITCH
  } event_t;

  typedef enum logic [1:0] {
    CFG_AIR_DELAY, CFG_MAIN_HOLD, CFG_SUB_HOLD, CFG_UNUSED
  } cfg_idx_t;

  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  localparam int O_MOTOR = 0;
  localparam int O_MWORK = 1;
  localparam int O_SWORK = 2;
  localparam int O_MAIR  = 3;
  localparam int O_SAIR  = 4;
  localparam int O_DROP  = 5;

  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] AIR_DELAY_RST = 16'd200;
  localparam logic [CFG_W-1:0] MAIN_HOLD_RST = 16'd3000;
  localparam logic [CFG_W-1:0] SUB_HOLD_RST  = 16'd1500;

endpackage
`default_nettype wire

@@ design/scissor_lift_valve_sequencer.sv @@
// Top level of the scissor lift valve sequencer.
// Returns exactly one result word per accepted word, registered on acceptance in a single
// output register; in_ready stays high while that register is empty or being drained, so
// back-to-back words flow at one per cycle while out_ready is high. The sequence state,
// timers and role are updated as a word is accepted, by one pass of shallow logic (two
// TIME_BITS-wide subtracts and compares). Elapsed time wraps modulo 2^TIME_BITS, and only
// the low TIME_BITS bits of now_ms are used. Configuration writes take effect at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module scissor_lift_valve_sequencer #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] now_ms,
  input  wire logic        rotary_main,
  input  wire logic        up_button,
  input  wire logic        down_button,
  input  wire logic        lock_button,
  input  wire logic        refill_button,
  input  wire logic        main_upper_limit,
  input  wire logic        sub_upper_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             motor_on,
  output logic             main_work_valve_on,
  output logic             sub_work_valve_on,
  output logic             main_air_valve_on,
  output logic             sub_air_valve_on,
  output logic             drop_valve_on,
  output logic [2:0]       lift_status,
  output logic [3:0]       event_code,
  output logic [15:0]      event_duration_ms,
  output logic             rearm_request,
  output logic             role_is_main
);

  logic [slvs_pkg::CFG_W-1:0] air_wait, main_hold, sub_hold;

  slvs_pkg::seq_t    seq, seq_next;
  slvs_pkg::status_t status, status_next;
  logic [TIME_BITS-1:0] act_start, act_start_next, ph_start, ph_start_next;
  logic [2:0] prev_btn, prev_btn_next;
  logic role, role_next, role_sampled, role_sampled_next;
  logic [5:0] levels, levels_next;
  slvs_pkg::event_t ev;
  logic [15:0] dur;
  logic rearm;

  logic [TIME_BITS-1:0] now_t, ph, act;
  logic role_cur, lim, accept;
  logic [slvs_pkg::CFG_W-1:0] hold;
  logic [5:0] work_bit, air_bit, drop_bit, motor_bit;

  function automatic logic [5:0] force_down(input logic [5:0] l, input logic [5:0] w,
                                            input logic [5:0] a, input logic [5:0] d,
                                            input logic [5:0] m);
    force_down = (l & ~m) | w | a | d;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign now_t    = now_ms[TIME_BITS-1:0];
  assign role_cur = role_sampled ? role : rotary_main;
  assign lim      = role_cur ? main_upper_limit : sub_upper_limit;
  assign hold     = role_cur ? main_hold : sub_hold;
  assign ph       = now_t - ph_start;
  assign act      = now_t - act_start;

  always_comb begin
    work_bit  = '0;
    air_bit   = '0;
    drop_bit  = '0;
    motor_bit = '0;
    work_bit[role_cur ? slvs_pkg::O_MWORK : slvs_pkg::O_SWORK] = 1'b1;
    air_bit[role_cur ? slvs_pkg::O_MAIR : slvs_pkg::O_SAIR]    = 1'b1;
    drop_bit[slvs_pkg::O_DROP]   = 1'b1;
    motor_bit[slvs_pkg::O_MOTOR] = 1'b1;
  end

  always_comb begin
    seq_next          = seq;
    status_next       = status;
    act_start_next    = act_start;
    ph_start_next     = ph_start;
    prev_btn_next     = prev_btn;
    role_next         = role;
    role_sampled_next = role_sampled;
    levels_next       = levels;
    ev                = slvs_pkg::EV_NONE;
    dur               = '0;
    rearm             = 1'b0;
    if (kind == slvs_pkg::KIND_ABORT) begin
      levels_next    = '0;
      seq_next       = slvs_pkg::SQ_IDLE;
      act_start_next = '0;
      ph_start_next  = '0;
      status_next    = slvs_pkg::ST_IDLE;
    end else if (rotary_main != role_cur) begin
      role_sampled_next = 1'b1;
      levels_next       = '0;
      seq_next          = slvs_pkg::SQ_IDLE;
      ph_start_next     = '0;
      status_next       = slvs_pkg::ST_IDLE;
      role_next         = rotary_main;
      ev                = slvs_pkg::EV_ROLE_SWITCH;
      rearm             = 1'b1;
    end else begin
      role_sampled_next = 1'b1;
      role_next         = role_cur;
      case (seq)
        slvs_pkg::SQ_IDLE: begin
          if (up_button && refill_button) begin
            levels_next    = levels | motor_bit | work_bit;
            seq_next       = slvs_pkg::SQ_REFILL;
            act_start_next = now_t;
            ph_start_next  = now_t;
            status_next    = slvs_pkg::ST_REFILLING;
            ev             = slvs_pkg::EV_REFILL_START;
          end else if (up_button && !prev_btn[0]) begin
            if (!lim) begin
              levels_next    = levels | motor_bit | work_bit;
              act_start_next = now_t;
              ph_start_next  = now_t;
              seq_next       = slvs_pkg::SQ_UP_WAIT;
              status_next    = slvs_pkg::ST_RISING;
              ev             = slvs_pkg::EV_UP_START;
            end
          end else if (down_button && !prev_btn[1]) begin
            act_start_next = now_t;
            ph_start_next  = now_t;
            status_next    = slvs_pkg::ST_DROPPING;
            ev             = slvs_pkg::EV_DOWN_START;
            if (lim || lock_button) begin
              levels_next = force_down(levels, work_bit, air_bit, drop_bit, motor_bit);
              seq_next    = slvs_pkg::SQ_DN_DROP;
            end else begin
              levels_next = levels | motor_bit | work_bit;
              seq_next    = slvs_pkg::SQ_DN_1;
            end
          end else if (lock_button && !prev_btn[2]) begin
            levels_next    = levels | work_bit | drop_bit;
            seq_next       = slvs_pkg::SQ_LOCKED;
            act_start_next = now_t;
            ph_start_next  = now_t;
            status_next    = slvs_pkg::ST_LOCKED;
            ev             = slvs_pkg::EV_LOCK_START;
          end
        end
        slvs_pkg::SQ_UP_WAIT, slvs_pkg::SQ_UP_RUN: begin
          if (seq == slvs_pkg::SQ_UP_WAIT && ph >= TIME_BITS'(air_wait)) begin
            levels_next = levels | air_bit;
            seq_next    = slvs_pkg::SQ_UP_RUN;
          end
          if (lim || !up_button) begin
            levels_next   = '0;
            seq_next      = slvs_pkg::SQ_IDLE;
            ph_start_next = '0;
            status_next   = slvs_pkg::ST_IDLE;
            if (lim) begin
              ev = slvs_pkg::EV_UP_LIMIT;
            end else begin
              ev = slvs_pkg::EV_UP_RELEASE;
            end
            dur           = act[15:0];
          end
        end
        slvs_pkg::SQ_DN_1, slvs_pkg::SQ_DN_2, slvs_pkg::SQ_DN_DROP: begin
          if (seq == slvs_pkg::SQ_DN_1) begin
            if (ph >= TIME_BITS'(air_wait)) begin
              levels_next   = levels | air_bit;
              ph_start_next = now_t;
              seq_next      = slvs_pkg::SQ_DN_2;
            end
          end else if (seq == slvs_pkg::SQ_DN_2) begin
            if (ph >= TIME_BITS'(hold)) begin
              levels_next = force_down(levels, work_bit, air_bit, drop_bit, motor_bit);
              seq_next    = slvs_pkg::SQ_DN_DROP;
              status_next = slvs_pkg::ST_DROPPING;
            end
          end
          if (lim || lock_button) begin
            levels_next = force_down(levels_next, work_bit, air_bit, drop_bit, motor_bit);
            seq_next    = slvs_pkg::SQ_DN_DROP;
            status_next = slvs_pkg::ST_DROPPING;
          end
          if (!down_button) begin
            levels_next   = '0;
            seq_next      = slvs_pkg::SQ_IDLE;
            ph_start_next = '0;
            status_next   = slvs_pkg::ST_IDLE;
            ev            = slvs_pkg::EV_DOWN_RELEASE;
            dur           = act[15:0];
          end
        end
        slvs_pkg::SQ_LOCKED: begin
          if (!lock_button) begin
            levels_next   = '0;
            seq_next      = slvs_pkg::SQ_IDLE;
            ph_start_next = '0;
            status_next   = slvs_pkg::ST_IDLE;
            ev            = slvs_pkg::EV_LOCK_STOP;
            dur           = act[15:0];
          end
        end
        default: begin
          if (ph >= TIME_BITS'(air_wait)) begin
            levels_next = levels | air_bit;
          end
          if (!up_button || !refill_button) begin
            levels_next   = '0;
            seq_next      = slvs_pkg::SQ_IDLE;
            ph_start_next = '0;
            status_next   = slvs_pkg::ST_IDLE;
            ev            = slvs_pkg::EV_REFILL_STOP;
            dur           = act[15:0];
          end
        end
      endcase
      prev_btn_next = {lock_button, down_button, up_button};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      air_wait  <= slvs_pkg::AIR_DELAY_RST;
      main_hold <= slvs_pkg::MAIN_HOLD_RST;
      sub_hold  <= slvs_pkg::SUB_HOLD_RST;
    end else if (cfg_we) begin
      case (slvs_pkg::cfg_idx_t'(cfg_index))
        slvs_pkg::CFG_AIR_DELAY: air_wait  <= cfg_data;
        slvs_pkg::CFG_MAIN_HOLD: main_hold <= cfg_data;
        slvs_pkg::CFG_SUB_HOLD:  sub_hold  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= slvs_pkg::SQ_IDLE;
      status       <= slvs_pkg::ST_IDLE;
      act_start    <= '0;
      ph_start     <= '0;
      prev_btn     <= '0;
      role         <= 1'b1;
      role_sampled <= 1'b0;
      levels       <= '0;
    end else if (accept) begin
      seq          <= seq_next;
      status       <= status_next;
      act_start    <= act_start_next;
      ph_start     <= ph_start_next;
      prev_btn     <= prev_btn_next;
      role         <= role_next;
      role_sampled <= role_sampled_next;
      levels       <= levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      motor_on           <= levels_next[slvs_pkg::O_MOTOR];
      main_work_valve_on <= levels_next[slvs_pkg::O_MWORK];
      sub_work_valve_on  <= levels_next[slvs_pkg::O_SWORK];
      main_air_valve_on  <= levels_next[slvs_pkg::O_MAIR];
      sub_air_valve_on   <= levels_next[slvs_pkg::O_SAIR];
      drop_valve_on      <= levels_next[slvs_pkg::O_DROP];
      lift_status        <= status_next;
      event_code         <= ev;
      event_duration_ms  <= dur;
      rearm_request      <= rearm;
      role_is_main       <= role_next;
    end
  end

  `ASSERT_IMPLIES(a_idle_outputs_off, clk, rst, seq == slvs_pkg::SQ_IDLE, levels == '0)
  `ASSERT_IMPLIES(a_no_motor_with_drop, clk, rst, out_valid, !(motor_on && drop_valve_on))
  `ASSERT_IMPLIES(a_rearm_on_switch, clk, rst, out_valid && rearm_request,
                  event_code == slvs_pkg::EV_ROLE_SWITCH)
  `ASSERT_NEXT(a_abort_clears, clk, rst, accept && kind == slvs_pkg::KIND_ABORT,
               out_valid && lift_status == slvs_pkg::ST_IDLE &&
               event_code == slvs_pkg::EV_NONE)

endmodule
`default_nettype wire
